// File: hw/rtl/egc_pkg.sv
package egc_pkg;

    // graph size limit and field widths
    localparam int MAX_VERTICES = 8;
    localparam int KIND_W       = 2;
    localparam int VTX_W        = 3;
    localparam int COL_W        = 4;
    localparam int CNT_W        = 4;

    // apb register map
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam logic [PADDR_W-1:0] REG_VERTEX_COUNT = 3'd0;

    // reset value of the vertex count register
    localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = CNT_W'(MAX_VERTICES);

    // input item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD   = 2'd0,
        KIND_SOLVE = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    typedef logic [VTX_W-1:0] t_vertex;
    typedef logic [COL_W-1:0] t_colour;
    typedef logic [CNT_W-1:0] t_count;

endpackage

// File: hw/rtl/egc_in_if.sv
interface egc_in_if;
    import egc_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    t_vertex           vertex_a;
    t_vertex           vertex_b;

    modport source (output valid, output kind, output vertex_a, output vertex_b,
                    input ready);
    modport sink   (input valid, input kind, input vertex_a, input vertex_b,
                    output ready);
endinterface

// File: hw/rtl/egc_out_if.sv
interface egc_out_if;
    import egc_pkg::*;

    logic    valid;
    logic    ready;
    t_vertex vertex;
    t_colour colour;
    t_count  chromatic_number;
    logic    last;

    modport source (output valid, output vertex, output colour,
                    output chromatic_number, output last, input ready);
    modport sink   (input valid, input vertex, input colour,
                    input chromatic_number, input last, output ready);
endinterface

// File: hw/rtl/exhaustive_graph_colouring.sv
// Minimum-colour assignment for a graph of up to eight vertices. Add-edge and
// clear beats update the graph when taken. A solve beat starts a depth-first
// search that tries colour limits 1, 2, ... and, for each limit, colourings in
// lexicographic order; each search step advances one vertex's colour, checks it
// against all earlier neighbors in one parallel compare row, then descends or
// backtracks, and the number of steps a solve takes depends on the graph. The
// results then go out one beat per cycle while the receiver is ready, one per
// vertex in use, with last on the final one. The input is not ready while a
// solve is searching or emitting. vertex_count is written over APB at byte
// address 0 and should only be changed while the block is idle.
module exhaustive_graph_colouring (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    egc_in_if.sink                   i_in,
    egc_out_if.source                o_out,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [egc_pkg::PADDR_W-1:0] paddr,
    input  logic [egc_pkg::PDATA_W-1:0] pwdata,
    output logic [egc_pkg::PDATA_W-1:0] prdata,
    output logic                     pready
);
    import egc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_EMIT   = 3'b100
    } t_state;

    t_state                    r_state;
    t_count                    r_vcount;
    logic [MAX_VERTICES-1:0]   r_adj [MAX_VERTICES];
    t_colour                   r_col [MAX_VERTICES];
    t_vertex                   r_pos;
    t_count                    r_lim;
    t_vertex                   r_emit;

    logic                      r_ovalid;
    t_vertex                   r_overtex;
    t_colour                   r_ocolour;
    t_count                    r_ochrom;
    logic                      r_olast;

    t_count                    n_used;
    t_colour                   cur_col;
    t_colour                   cand;
    logic                      over;
    logic [MAX_VERTICES-1:0]   hit;
    logic                      clash;
    logic                      pos_last;
    logic                      emit_last;
    logic                      in_beat;
    logic                      out_free;
    logic                      cfg_wr;

    // apb register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == 1'b0);

    always_comb begin
        prdata = '0;
        if (paddr[PADDR_W-1] == 1'b0) begin
            prdata[CNT_W-1:0] = r_vcount;
        end
    end

    // vertices in use, clamped to 1..MAX_VERTICES
    always_comb begin
        if (r_vcount == '0) begin
            n_used = CNT_W'(1);
        end else if (r_vcount > CNT_W'(MAX_VERTICES)) begin
            n_used = CNT_W'(MAX_VERTICES);
        end else begin
            n_used = r_vcount;
        end
    end

    // shared trial unit: next colour for the current vertex and its neighbor check
    assign cur_col = r_col[r_pos];
    assign cand    = cur_col + COL_W'(1);
    assign over    = cand > r_lim;

    always_comb begin
        for (int q = 0; q < MAX_VERTICES; q++) begin
            hit[q] = (VTX_W'(q) < r_pos) && r_adj[r_pos][q] && (r_col[q] == cand);
        end
    end

    assign clash     = |hit;
    assign pos_last  = (CNT_W'(r_pos) + CNT_W'(1)) == n_used;
    assign emit_last = (CNT_W'(r_emit) + CNT_W'(1)) == n_used;

    // handshakes
    assign i_in.ready = (r_state == S_IDLE);
    assign in_beat    = i_in.valid && i_in.ready;
    assign out_free   = !r_ovalid || o_out.ready;

    assign o_out.valid            = r_ovalid;
    assign o_out.vertex           = r_overtex;
    assign o_out.colour           = r_ocolour;
    assign o_out.chromatic_number = r_ochrom;
    assign o_out.last             = r_olast;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VERTEX_COUNT_RST;
        end else if (cfg_wr) begin
            r_vcount <= pwdata[CNT_W-1:0];
        end
    end

    // adjacency rows: edge adds set a symmetric pair, clear empties all
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < MAX_VERTICES; r++) begin
                r_adj[r] <= '0;
            end
        end else if (in_beat) begin
            case (t_kind'(i_in.kind))
                KIND_ADD: begin
                    if (int'(i_in.vertex_a) < MAX_VERTICES &&
                        int'(i_in.vertex_b) < MAX_VERTICES) begin
                        r_adj[i_in.vertex_a][i_in.vertex_b] <= 1'b1;
                        r_adj[i_in.vertex_b][i_in.vertex_a] <= 1'b1;
                    end
                end
                KIND_CLEAR: begin
                    for (int r = 0; r < MAX_VERTICES; r++) begin
                        r_adj[r] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // output valid: loaded while emitting, dropped once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_free) begin
            r_ovalid <= (r_state == S_EMIT);
        end
    end

    // search sequencer and result emission
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= '0;
            r_lim    <= CNT_W'(1);
            r_emit   <= '0;
            for (int v = 0; v < MAX_VERTICES; v++) begin
                r_col[v] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_beat && t_kind'(i_in.kind) == KIND_SOLVE) begin
                        r_state <= S_SEARCH;
                        r_pos   <= '0;
                        r_lim   <= CNT_W'(1);
                        for (int v = 0; v < MAX_VERTICES; v++) begin
                            r_col[v] <= '0;
                        end
                    end
                end
                S_SEARCH: begin
                    if (over) begin
                        // colours exhausted at this vertex: backtrack or raise limit
                        r_col[r_pos] <= '0;
                        if (r_pos == '0) begin
                            r_lim <= r_lim + CNT_W'(1);
                        end else begin
                            r_pos <= r_pos - VTX_W'(1);
                        end
                    end else begin
                        r_col[r_pos] <= cand;
                        if (!clash) begin
                            if (pos_last) begin
                                r_state <= S_EMIT;
                                r_emit  <= '0;
                            end else begin
                                r_pos <= r_pos + VTX_W'(1);
                                r_col[r_pos + VTX_W'(1)] <= '0;
                            end
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_overtex <= r_emit;
                        r_ocolour <= r_col[r_emit];
                        r_ochrom  <= r_lim;
                        r_olast   <= emit_last;
                        if (emit_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_emit <= r_emit + VTX_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: sim/exhaustive_graph_colouring_tb.sv
module exhaustive_graph_colouring_tb;
    import egc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // kind code that the block must ignore
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 125;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        t_vertex vertex;
        t_colour colour;
        t_count  chrom;
        logic    last;
    } t_colour_report;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    egc_in_if  in_ch ();
    egc_out_if out_ch ();

    exhaustive_graph_colouring dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow copy of the graph and the vertex count register
    bit             adj_bits [MAX_VERTICES][MAX_VERTICES];
    logic [CNT_W-1:0] vcount_reg = VERTEX_COUNT_RST;
    int             trial_colour [MAX_VERTICES];

    t_colour_report pending_colours [$];
    int             failures = 0;
    bit             no_idle = 1'b0;

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(400_000_000);
        $display("== FAIL ==");
        $finish;
    end

    // vertices in use after clamping the register
    function automatic int used_count();
        if (vcount_reg == 0)
            return 1;
        if (vcount_reg > MAX_VERTICES)
            return MAX_VERTICES;
        return int'(vcount_reg);
    endfunction

    // depth-first search for the first proper colouring with k colours
    function automatic bit fits_in_colours(int k, int n);
        int  pos;
        bit  clash;
        pos = 0;
        trial_colour[0] = 0;
        while (1) begin
            trial_colour[pos]++;
            if (trial_colour[pos] > k) begin
                trial_colour[pos] = 0;
                pos--;
                if (pos < 0)
                    return 1'b0;
            end else begin
                clash = 1'b0;
                for (int q = 0; q < pos; q++)
                    if (adj_bits[q][pos] && trial_colour[q] == trial_colour[pos])
                        clash = 1'b1;
                if (!clash) begin
                    pos++;
                    if (pos == n)
                        return 1'b1;
                    trial_colour[pos] = 0;
                end
            end
        end
        return 1'b0;
    endfunction

    // minimum colouring, queued as one report per vertex in use
    function automatic void find_colouring();
        int             n;
        int             chrom;
        bit             found;
        t_colour_report r;
        n = used_count();
        chrom = n;
        found = 1'b0;
        for (int k = 1; k <= n && !found; k++) begin
            for (int v = 0; v < MAX_VERTICES; v++)
                trial_colour[v] = 0;
            if (fits_in_colours(k, n)) begin
                found = 1'b1;
                chrom = k;
            end
        end
        for (int v = 0; v < n; v++) begin
            r.vertex = v[VTX_W-1:0];
            r.colour = trial_colour[v][COL_W-1:0];
            r.chrom  = chrom[CNT_W-1:0];
            r.last   = (v + 1 == n);
            pending_colours.push_back(r);
        end
    endfunction

    // update the shadow graph for one accepted beat
    function automatic void apply_beat(logic [KIND_W-1:0] kind, t_vertex a, t_vertex b);
        case (kind)
            KIND_ADD: begin
                adj_bits[a][b] = 1'b1;
                adj_bits[b][a] = 1'b1;
            end
            KIND_CLEAR: begin
                for (int i = 0; i < MAX_VERTICES; i++)
                    for (int j = 0; j < MAX_VERTICES; j++)
                        adj_bits[i][j] = 1'b0;
            end
            KIND_SOLVE: find_colouring();
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // send one input beat after a random gap
    task automatic send_beat(logic [KIND_W-1:0] kind, t_vertex a, t_vertex b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.kind     <= kind;
        in_ch.vertex_a <= a;
        in_ch.vertex_b <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        apply_beat(kind, a, b);
    endtask

    // endpoint mostly among the vertices in use
    function automatic t_vertex pick_vertex();
        if ($urandom_range(0, 4) == 0)
            return t_vertex'($urandom_range(0, MAX_VERTICES - 1));
        return t_vertex'($urandom_range(0, used_count() - 1));
    endfunction

    // stop sending and let every expected report drain
    task automatic go_idle();
        in_ch.valid <= 1'b0;
        while (pending_colours.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb write of the vertex count register, upper bits random
    task automatic write_vertex_count(logic [CNT_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_VERTEX_COUNT;
        pwdata  <= ($urandom() & ~32'(4'hF)) | 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        vcount_reg = val;
    endtask

    // result side: random stalls, each beat checked against the oldest report
    initial begin
        int             stall;
        t_colour_report want;
        out_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            if (pending_colours.size() == 0) begin
                $error("unexpected beat: vertex %0d colour %0d", out_ch.vertex, out_ch.colour);
                failures++;
            end else begin
                want = pending_colours.pop_front();
                check_field("vertex", 32'(want.vertex), 32'(out_ch.vertex));
                check_field("colour", 32'(want.colour), 32'(out_ch.colour));
                check_field("chromatic_number", 32'(want.chrom),
                            32'(out_ch.chromatic_number));
                check_field("last", 32'(want.last), 32'(out_ch.last));
            end
        end
    end

    // solve on the empty graph at the reset vertex count
    task automatic test_empty_graph();
        send_beat(KIND_SOLVE, 3'd0, 3'd0);
    endtask

    // corner endpoints, a repeated edge and a self loop
    task automatic test_edge_extremes();
        send_beat(KIND_ADD, 3'd0, 3'd7);
        send_beat(KIND_ADD, 3'd7, 3'd0);
        send_beat(KIND_ADD, 3'd3, 3'd3);
        send_beat(KIND_ADD, 3'd5, 3'd2);
        send_beat(KIND_UNUSED, 3'd7, 3'd7);
        send_beat(KIND_SOLVE, 3'd7, 3'd7);
    endtask

    // one vertex, a zero count and a count above the limit
    task automatic test_count_clamping();
        go_idle();
        write_vertex_count(4'd1);
        send_beat(KIND_ADD, 3'd0, 3'd1);
        send_beat(KIND_SOLVE, 3'd0, 3'd0);
        go_idle();
        write_vertex_count(4'd0);
        send_beat(KIND_SOLVE, 3'd0, 3'd0);
        go_idle();
        write_vertex_count(4'd15);
        send_beat(KIND_SOLVE, 3'd0, 3'd0);
    endtask

    // triangle needs three colours, edge on unused vertices is ignored
    task automatic test_odd_cycle();
        go_idle();
        write_vertex_count(4'd3);
        send_beat(KIND_CLEAR, 3'd5, 3'd6);
        send_beat(KIND_ADD, 3'd0, 3'd1);
        send_beat(KIND_ADD, 3'd1, 3'd2);
        send_beat(KIND_ADD, 3'd2, 3'd0);
        send_beat(KIND_ADD, 3'd4, 3'd6);
        send_beat(KIND_SOLVE, 3'd0, 3'd0);
    endtask

    // random graphs, counts and edges, each set ending in a solve
    task automatic test_random_graphs();
        int               sent;
        int               edges;
        int               pick;
        logic [CNT_W-1:0] vc;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0) begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    vc = CNT_W'($urandom_range(1, 6));
                else if (pick < 8)
                    vc = CNT_W'($urandom_range(7, 8));
                else
                    vc = CNT_W'($urandom_range(0, 15));
                go_idle();
                write_vertex_count(vc);
            end
            if ($urandom_range(0, 4) != 0) begin
                send_beat(KIND_CLEAR, t_vertex'($urandom()), t_vertex'($urandom()));
                sent++;
            end
            edges = $urandom_range(0, 10);
            repeat (edges) begin
                send_beat(KIND_ADD, pick_vertex(), pick_vertex());
                sent++;
                if ($urandom_range(0, 9) == 0)
                    send_beat(KIND_UNUSED, t_vertex'($urandom()), t_vertex'($urandom()));
            end
            send_beat(KIND_SOLVE, t_vertex'($urandom()), t_vertex'($urandom()));
            sent++;
            if ($urandom_range(0, 5) == 0) begin
                send_beat(KIND_SOLVE, t_vertex'($urandom()), t_vertex'($urandom()));
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    // complete graph on all eight vertices needs eight colours
    task automatic test_complete_graph();
        go_idle();
        write_vertex_count(4'd8);
        send_beat(KIND_CLEAR, 3'd0, 3'd0);
        for (int i = 0; i < MAX_VERTICES; i++)
            for (int j = i + 1; j < MAX_VERTICES; j++)
                if ($urandom_range(0, 1) == 0)
                    send_beat(KIND_ADD, t_vertex'(i), t_vertex'(j));
                else
                    send_beat(KIND_ADD, t_vertex'(j), t_vertex'(i));
        send_beat(KIND_SOLVE, 3'd0, 3'd0);
    endtask

    // main sequence
    initial begin
        in_ch.valid    <= 1'b0;
        in_ch.kind     <= KIND_ADD;
        in_ch.vertex_a <= '0;
        in_ch.vertex_b <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= REG_VERTEX_COUNT;
        pwdata         <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_graph();
        test_edge_extremes();
        test_count_clamping();
        test_odd_cycle();
        test_random_graphs();
        test_complete_graph();

        go_idle();
        repeat (20) @(posedge i_clk);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
